FILE: rtl/log_scale_color_map_macros.svh
// ----------------------------------------------------------------------------
// log scale color map assertion macros
// shared property wrappers for the color map checks
// ----------------------------------------------------------------------------
`ifndef LOG_SCALE_COLOR_MAP_MACROS_SVH
`define LOG_SCALE_COLOR_MAP_MACROS_SVH

// implication checked every clock, off during reset
`define LSCM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication checked every clock, off during reset
`define LSCM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/lscm_pkg.sv
// ----------------------------------------------------------------------------
// log scale color map package
// types, constants and register indexes
// ----------------------------------------------------------------------------
package lscm_pkg;
	localparam int TableDepth = 256;
	localparam int TableAw = $clog2(TableDepth);
	localparam int FracBits = 16;
	localparam int LogSteps = FracBits;
	localparam logic [31:0] Log10Of2Q32 = 32'd1292913986;

	typedef enum logic [2:0] {
		REG_RANGE_MIN = 3'd0,
		REG_RANGE_MAX = 3'd1,
		REG_USE_MAG = 3'd2,
		REG_LOG_START = 3'd3,
		REG_INDEX_SCALE = 3'd4,
		REG_COLOR_COUNT = 3'd5,
		REG_OUT_FORMAT = 3'd6
	} reg_idx_t;

	localparam logic KIND_MAP = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [TableAw-1:0] tidx;
		logic [31:0] rgba;
		logic        last;
	} side_t;

	// one squaring step of the log2 fraction
	function automatic logic [32:0] sq_step(input logic [31:0] x, output logic bit_o);
		logic [63:0] p;
		logic [32:0] y;
		p = 64'(x) * 64'(x);
		y = 33'(p >> 31);
		bit_o = y[32];
		return y[32] ? (y >> 1) : y;
	endfunction
endpackage

FILE: rtl/lscm_ram.sv
// ----------------------------------------------------------------------------
// lscm ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module lscm_ram #(
	parameter int Width = 32,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/log_scale_color_map.sv
// ----------------------------------------------------------------------------
// log scale color map
// Maps each sample to a color through a base-10 log scale and a loaded RGBA
// table; tuser=1 words load a table entry and produce no output. The
// pipeline takes one word per clock and runs these stages in order: clamp,
// leading-one search, sixteen squaring stages for the log2 fraction, log10
// multiply, offset, scale multiply, clamp, the table ram read and the output
// register. Table writes ride the same pipeline and hit the ram in order with
// reads. While an output word waits on m_tready the whole pipe holds.
// ----------------------------------------------------------------------------
`include "log_scale_color_map_macros.svh"

module log_scale_color_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // sample[31:0], table_index[39:32], entry_rgba[71:40]
	input  logic        s_tuser,   // kind
	input  logic        s_tlast,   // last_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_bytes[31:0], byte_count[34:32], color_index[42:35]
	output logic        m_tlast,   // last_out
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import lscm_pkg::*;

	localparam int NStg = 23;

	logic signed [31:0] range_min_q, range_max_q;
	logic        use_mag_q;
	logic [19:0] log_start_q;
	logic [31:0] index_scale_q;
	logic [8:0]  color_count_q;
	logic [2:0]  format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= 32'sd1;
			range_max_q <= 32'sd10;
			use_mag_q <= 1'b0;
			log_start_q <= '0;
			index_scale_q <= 32'd16711680;
			color_count_q <= 9'd256;
			format_q <= 3'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_MIN: range_min_q <= cfg_wdata;
				REG_RANGE_MAX: range_max_q <= cfg_wdata;
				REG_USE_MAG: use_mag_q <= cfg_wdata[0];
				REG_LOG_START: log_start_q <= cfg_wdata[19:0];
				REG_INDEX_SCALE: index_scale_q <= cfg_wdata;
				REG_COLOR_COUNT: color_count_q <= cfg_wdata[8:0];
				REG_OUT_FORMAT: format_q <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// pipeline control: whole pipe advances when output is free
	logic [NStg-1:0] vld_q;
	logic [NStg-1:0] emit_q;
	logic adv;
	logic out_full_q;
	assign adv = !out_full_q || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			emit_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NStg-2:0], s_tvalid};
			emit_q <= {emit_q[NStg-2:0], s_tvalid && (s_tuser == KIND_MAP)};
		end
	end

	side_t side_q [NStg];
	side_t side_in;
	assign side_in = '{kind: s_tuser, tidx: s_tdata[32 +: TableAw],
		rgba: s_tdata[71:40], last: s_tlast};

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_in;
			for (int i = 1; i < NStg; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// s1: clamp and magnitude
	logic signed [31:0] smp, clampd;
	logic signed [32:0] mag_c;
	logic [31:0] mag_s1;
	always_comb begin
		smp = s_tdata[31:0];
		if (smp < range_min_q) clampd = range_min_q;
		else if (smp > range_max_q) clampd = range_max_q;
		else clampd = smp;
		mag_c = use_mag_q ? -33'(clampd) : 33'(clampd);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= (mag_c < 33'sd1) ? 32'd1 : mag_c[31:0];
		end
	end

	// s2: leading one and normalize to q1.31
	logic [4:0] e_c;
	logic [4:0] e_s2;
	logic [31:0] x_s2;
	always_comb begin
		e_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (mag_s1[i]) e_c = 5'(i);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			e_s2 <= e_c;
			x_s2 <= mag_s1 << (5'd31 - e_c);
		end
	end

	// squaring stages: one fraction bit each
	logic [31:0] xq [LogSteps+1];
	logic [FracBits-1:0] fq [LogSteps+1];
	logic [4:0] eq [LogSteps+1];
	assign xq[0] = x_s2;
	assign fq[0] = '0;
	assign eq[0] = e_s2;
	for (genvar k = 0; k < LogSteps; k++) begin : g_sq
		logic [32:0] y;
		logic b;
		always_comb y = sq_step(xq[k], b);
		always_ff @(posedge clk) begin
			if (adv) begin
				xq[k+1] <= y[31:0];
				fq[k+1] <= {fq[k][FracBits-2:0], b};
				eq[k+1] <= eq[k];
			end
		end
	end

	// log10 multiply
	logic [52:0] prod_c;
	logic [20:0] lg_s19;
	assign prod_c = 53'({eq[LogSteps], fq[LogSteps]}) * 53'(Log10Of2Q32);
	always_ff @(posedge clk) begin
		if (adv) lg_s19 <= 21'(prod_c >> 32);
	end

	// distance
	logic [20:0] dist_s20;
	logic [20:0] ls;
	assign ls = 21'(log_start_q);
	always_ff @(posedge clk) begin
		if (adv) begin
			if (use_mag_q) dist_s20 <= (ls > lg_s19) ? ls - lg_s19 : '0;
			else dist_s20 <= (lg_s19 > ls) ? lg_s19 - ls : '0;
		end
	end

	// scale multiply
	logic [52:0] sc_s21;
	always_ff @(posedge clk) begin
		if (adv) sc_s21 <= 53'(dist_s20) * 53'(index_scale_q);
	end

	// index clamp
	logic [20:0] idx_full;
	logic [8:0] colors;
	logic [TableAw-1:0] idx_s22;
	always_comb begin
		idx_full = 21'(sc_s21 >> (FracBits + 16));
		if (color_count_q == 9'd0) colors = 9'd1;
		else if (color_count_q > 9'(TableDepth)) colors = 9'(TableDepth);
		else colors = color_count_q;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s22 <= (idx_full > 21'(colors - 9'd1)) ? TableAw'(colors - 9'd1)
				: idx_full[TableAw-1:0];
		end
	end

	// ram: writes and reads in pipeline order at stage 22
	logic [31:0] rdata;
	logic [TableAw-1:0] idx_s23;
	side_t sw;
	assign sw = side_q[NStg-2];
	lscm_ram #(.Width(32), .Depth(TableDepth)) u_ram (
		.clk(clk),
		.we(adv && vld_q[NStg-2] && sw.kind == KIND_WRITE),
		.waddr(sw.tidx),
		.wdata(sw.rgba),
		.re(adv),
		.raddr(idx_s22),
		.rdata(rdata)
	);
	always_ff @(posedge clk) begin
		if (adv) idx_s23 <= idx_s22;
	end

	// format and output register
	logic [2:0] fmt;
	logic [31:0] bytes_c;
	always_comb begin
		if (format_q == 3'd0) fmt = 3'd1;
		else if (format_q > 3'd4) fmt = 3'd4;
		else fmt = format_q;
		case (fmt)
			3'd1: bytes_c = {24'd0, rdata[7:0]};
			3'd2: bytes_c = {16'd0, rdata[31:24], rdata[7:0]};
			3'd3: bytes_c = {8'd0, rdata[23:0]};
			default: bytes_c = rdata;
		endcase
	end

	logic [47:0] odata_q;
	logic olast_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (adv) begin
			out_full_q <= emit_q[NStg-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			odata_q <= {5'd0, 8'(idx_s23), fmt, bytes_c};
			olast_q <= side_q[NStg-1].last;
		end
	end

	assign m_tvalid = out_full_q;
	assign m_tdata = odata_q;
	assign m_tlast = olast_q;

	`LSCM_ASSERT_IMP(a_emit_valid, emit_q[NStg-1], vld_q[NStg-1])
	`LSCM_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`LSCM_ASSERT_IMP(a_count, m_tvalid, m_tdata[34:32] >= 3'd1 && m_tdata[34:32] <= 3'd4)
endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// log scale color map testbench
// Loads the color table, walks a table of directed samples, then drives
// random samples and table writes through several register settings with
// random idling on both sides and one long output hold-off. Every output
// word is checked field by field against fixed or in-bench predicted values.
// ----------------------------------------------------------------------------
module tb_top;
	import lscm_pkg::*;

	localparam int Latency = 24;
	localparam int WatchdogLimit = 20000;

	typedef struct {
		logic        kind;
		logic [31:0] sample;
		logic [7:0]  tidx;
		logic [31:0] rgba;
		logic        last;
	} word_t;

	typedef struct {
		logic [31:0] bytes;
		logic [2:0]  count;
		logic [7:0]  cidx;
		logic        last;
	} color_t;

	typedef struct {
		word_t w;
		logic  has_exp;
		color_t e;
	} row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser, s_tlast;
	logic [71:0] s_tdata;
	logic m_tvalid, m_tready, m_tlast;
	logic [47:0] m_tdata;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_wdata;

	logic signed [31:0] p_min, p_max;
	logic p_mag;
	logic [19:0] p_start;
	logic [31:0] p_scale;
	logic [8:0] p_count;
	logic [2:0] p_fmt;
	logic [31:0] p_table [256];

	color_t colors_due[$];
	int errors;
	int idle_count;
	bit in_idle_on, out_idle_on, hold_off;

	log_scale_color_map i_dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] log10_q16(logic [31:0] m);
		int e;
		logic [63:0] x, frac;
		e = 0;
		for (int b = 0; b < 32; b++) if (m[b]) e = b;
		x = 64'(m) << (31 - e);
		frac = 0;
		for (int k = 0; k < FracBits; k++) begin
			x = (x * x) >> 31;
			frac = frac << 1;
			if (x >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				x = x >> 1;
			end
		end
		return (((64'(e) << FracBits) | frac) * 64'(Log10Of2Q32)) >> 32;
	endfunction

	function automatic color_t map_color(word_t w);
		color_t r;
		logic signed [63:0] v, mag;
		logic [63:0] lg, span, idx, cnt, rgba;
		logic [2:0] fmt;
		v = $signed(w.sample);
		if (v < 64'(p_min)) v = p_min;
		else if (v > 64'(p_max)) v = p_max;
		mag = p_mag ? -v : v;
		if (mag < 1) mag = 1;
		lg = log10_q16(mag[31:0]);
		if (p_mag) span = (p_start > lg) ? p_start - lg : 0;
		else span = (lg > p_start) ? lg - p_start : 0;
		idx = (span * p_scale) >> (FracBits + 16);
		cnt = p_count;
		if (cnt < 1) cnt = 1;
		if (cnt > TableDepth) cnt = TableDepth;
		if (idx > cnt - 1) idx = cnt - 1;
		rgba = p_table[idx];
		fmt = p_fmt;
		if (fmt < 1) fmt = 1;
		if (fmt > 4) fmt = 4;
		case (fmt)
			1: r.bytes = {24'd0, rgba[7:0]};
			2: r.bytes = {16'd0, rgba[31:24], rgba[7:0]};
			3: r.bytes = {8'd0, rgba[23:0]};
			default: r.bytes = rgba[31:0];
		endcase
		r.count = fmt;
		r.cidx = idx[7:0];
		r.last = w.last;
		return r;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_RANGE_MIN: p_min = val;
			REG_RANGE_MAX: p_max = val;
			REG_USE_MAG: p_mag = val[0];
			REG_LOG_START: p_start = val[19:0];
			REG_INDEX_SCALE: p_scale = val;
			REG_COLOR_COUNT: p_count = val[8:0];
			REG_OUT_FORMAT: p_fmt = val[2:0];
			default: ;
		endcase
	endtask

	task automatic send_word(word_t w, logic has_exp, color_t e);
		color_t pr;
		while (in_idle_on && ($urandom_range(99) < 29)) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= w.kind;
		s_tlast <= w.last;
		s_tdata <= {w.rgba, w.tidx, w.sample};
		do @(posedge clk); while (!s_tready);
		if (w.kind == KIND_WRITE) begin
			p_table[w.tidx] = w.rgba;
		end else begin
			pr = map_color(w);
			colors_due.push_back(has_exp ? e : pr);
		end
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (colors_due.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	function automatic word_t wr_word(logic [7:0] ti, logic [31:0] c);
		word_t w;
		w.kind = KIND_WRITE; w.sample = $urandom; w.tidx = ti; w.rgba = c;
		w.last = 1'($urandom_range(1));
		return w;
	endfunction

	function automatic word_t map_word(logic [31:0] s, logic l);
		word_t w;
		w.kind = KIND_MAP; w.sample = s; w.tidx = 8'($urandom); w.rgba = $urandom;
		w.last = l;
		return w;
	endfunction

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(20);
			2: return -$urandom_range(20);
			3: return 32'h7fffffff - $urandom_range(3);
			4: return 32'h80000000 + $urandom_range(3);
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	task automatic random_phase(int n);
		color_t dummy;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				send_word(wr_word(8'($urandom), $urandom), 1'b0, dummy);
			else
				send_word(map_word(rand_sample(), 1'($urandom_range(1))), 1'b0, dummy);
		end
	endtask

	// output side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= hold_off ? 1'b0 :
				!(out_idle_on && ($urandom_range(99) < 29));
		end
	end

	always @(posedge clk) begin
		color_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (colors_due.size() == 0) begin
				$error("unexpected output word %h", m_tdata);
				errors++;
			end else begin
				e = colors_due.pop_front();
				if (m_tdata[31:0] !== e.bytes) begin
					$error("out_bytes exp %h got %h", e.bytes, m_tdata[31:0]); errors++;
				end
				if (m_tdata[34:32] !== e.count) begin
					$error("byte_count exp %0d got %0d", e.count, m_tdata[34:32]); errors++;
				end
				if (m_tdata[42:35] !== e.cidx) begin
					$error("color_index exp %0d got %0d", e.cidx, m_tdata[42:35]); errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last_out exp %0d got %0d", e.last, m_tlast); errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WatchdogLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		color_t z;
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tuser = 1'b0; s_tlast = 1'b0; s_tdata = '0;
		cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
		in_idle_on = 1'b1; out_idle_on = 1'b1; hold_off = 1'b0;
		p_min = 1; p_max = 10; p_mag = 0; p_start = 0; p_scale = 32'd16711680;
		p_count = 256; p_fmt = 4;
		z = '{default: 0};
		foreach (p_table[k]) p_table[k] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill whole table so every index is defined
		in_idle_on = 1'b0;
		for (int k = 0; k < 256; k++) send_word(wr_word(8'(k), $urandom), 1'b0, z);
		send_word(wr_word(8'd0, 32'h44332211), 1'b0, z);
		send_word(wr_word(8'd255, 32'hffffffff), 1'b0, z);
		in_idle_on = 1'b1;

		// directed, reset settings: 1 -> log 0 -> index 0, low samples clamp to 1
		r.has_exp = 1; r.w = map_word(32'd1, 1'b1);
		r.e = '{32'h44332211, 3'd4, 8'd0, 1'b1}; rows.push_back(r);
		r.w = map_word(32'h80000000, 1'b0);
		r.e = '{32'h44332211, 3'd4, 8'd0, 1'b0}; rows.push_back(r);
		r.has_exp = 0;
		r.w = map_word(32'h7fffffff, 1'b1); rows.push_back(r);
		for (int k = 0; k < 12; k++) begin
			r.w = map_word(32'(k - 1), k[0]); rows.push_back(r);
		end
		foreach (rows[k]) send_word(rows[k].w, rows[k].has_exp, rows[k].e);
		drain();

		// inverted range, negative mode, formats 0 and 2
		write_reg(REG_RANGE_MIN, 32'd100);
		write_reg(REG_RANGE_MAX, 32'd5);
		write_reg(REG_OUT_FORMAT, 32'd0);
		random_phase(10);
		drain();
		write_reg(REG_RANGE_MIN, 32'h80000000);
		write_reg(REG_RANGE_MAX, 32'hffffffff);
		write_reg(REG_USE_MAG, 32'd1);
		write_reg(REG_LOG_START, 32'd613270);
		write_reg(REG_INDEX_SCALE, 32'h0001_c000);
		write_reg(REG_OUT_FORMAT, 32'd2);
		random_phase(150);
		drain();

		// full range, count 0, format 7, large scale
		write_reg(REG_RANGE_MAX, 32'h7fffffff);
		write_reg(REG_USE_MAG, 32'd0);
		write_reg(REG_LOG_START, 32'd0);
		write_reg(REG_INDEX_SCALE, 32'hffffffff);
		write_reg(REG_COLOR_COUNT, 32'd0);
		write_reg(REG_OUT_FORMAT, 32'd7);
		random_phase(100);
		drain();

		// long stretch without idling, then long receiver hold-off
		write_reg(REG_RANGE_MIN, 32'd0);
		write_reg(REG_LOG_START, 32'd655360);
		write_reg(REG_INDEX_SCALE, 32'h0019_0000);
		write_reg(REG_COLOR_COUNT, 32'd300);
		write_reg(REG_OUT_FORMAT, 32'd3);
		in_idle_on = 1'b0; out_idle_on = 1'b0;
		random_phase(200);
		fork
			begin
				hold_off = 1'b1;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			random_phase(100);
		join
		in_idle_on = 1'b1; out_idle_on = 1'b1;
		drain();

		write_reg(REG_LOG_START, 32'd65536);
		write_reg(REG_INDEX_SCALE, 32'h0040_0000);
		write_reg(REG_COLOR_COUNT, 32'd17);
		write_reg(REG_OUT_FORMAT, 32'd1);
		random_phase(200);
		drain();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
